/* hw/rtl/cossim_pkg.sv */
`timescale 1ns / 1ps

package cossim_pkg;

    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = 48;
    localparam int SQ_W    = 2 * ACC_W;      // product of the two magnitudes
    localparam int HALF_W  = ACC_W / 2;      // partial-product operand width
    localparam int DIV_W   = ACC_W + 16;     // dividend width
    localparam int Q_W     = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [Q_W-2:0] SIM_MAX = {(Q_W-1){1'b1}};

    // Finished sums of one vector pair, passed from front to back.
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        mag_a;
        logic [ACC_W-1:0]        mag_b;
    } acc_rec_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_SQRT = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } back_state_t;

    // Saturating accumulate of one product into a 48-bit sum.
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] inc
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){inc[PROD_W-1]}}, inc};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            return s[ACC_W-1:0];
    endfunction

endpackage

/* hw/rtl/cossim_front.sv */
`timescale 1ns / 1ps

module cossim_front
    import cossim_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last_elem,
    output logic                     push,
    output acc_rec_t                 push_rec,
    input  logic                     q_full
);

    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_last_reg;
    logic signed [PROD_W-1:0] ab_reg, aa_reg, bb_reg;
    logic signed [ACC_W-1:0]  dot_reg, dot_next;
    logic signed [ACC_W-1:0]  maga_reg, maga_next;
    logic signed [ACC_W-1:0]  magb_reg, magb_next;
    logic signed [ACC_W-1:0]  dot_sum, maga_sum, magb_sum;
    logic                     s1_adv;
    logic                     take;

    // A marked pair waits in stage 1 until the queue has room.
    assign s1_adv   = s1_valid_reg && !(s1_last_reg && q_full);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign take     = in_valid && in_ready;

    assign dot_sum  = sat_add(dot_reg, ab_reg);
    assign maga_sum = sat_add(maga_reg, aa_reg);
    assign magb_sum = sat_add(magb_reg, bb_reg);

    assign push           = s1_adv && s1_last_reg;
    assign push_rec.dot   = dot_sum;
    assign push_rec.mag_a = maga_sum;
    assign push_rec.mag_b = magb_sum;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        dot_next      = dot_reg;
        maga_next     = maga_reg;
        magb_next     = magb_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                dot_next  = '0;
                maga_next = '0;
                magb_next = '0;
            end
            else
            begin
                dot_next  = dot_sum;
                maga_next = maga_sum;
                magb_next = magb_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            dot_reg      <= '0;
            maga_reg     <= '0;
            magb_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            dot_reg      <= dot_next;
            maga_reg     <= maga_next;
            magb_reg     <= magb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_last_reg <= last_elem;
            ab_reg      <= elem_a * elem_b;
            aa_reg      <= elem_a * elem_a;
            bb_reg      <= elem_b * elem_b;
        end
    end

endmodule

/* hw/rtl/cossim_queue.sv */
`timescale 1ns / 1ps

module cossim_queue
    import cossim_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  acc_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output acc_rec_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    acc_rec_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]         count_reg;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

/* hw/rtl/cossim_back.sv */
`timescale 1ns / 1ps

module cossim_back
    import cossim_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  acc_rec_t              head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [Q_W-1:0] similarity,
    output logic                  zero_magnitude
);

    back_state_t             state_reg, state_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [ACC_W-1:0]        ma_reg, mb_reg;
    logic [ACC_W-1:0]        mag_reg;
    logic                    neg_reg, zero_reg;
    logic [2*HALF_W-1:0]     pp_reg;
    logic [1:0]              pp_sh_reg;
    logic [SQ_W-1:0]         p_reg;
    logic [ACC_W-1:0]        rem_reg;
    logic [ACC_W-1:0]        root_reg;
    logic [DIV_W-1:0]        n_reg, d_reg;
    logic [Q_W-1:0]          q_reg;
    logic                    out_valid_reg;
    logic signed [Q_W-1:0]   sim_reg;
    logic                    zflag_reg;

    logic [HALF_W-1:0]       op_a, op_b;
    logic [SQ_W-1:0]         pp_placed;
    logic [ACC_W+1:0]        rem_ext, trial, rem_diff;
    logic                    rem_ge;
    logic [ACC_W-1:0]        root_next;
    logic                    n_ge;
    logic [Q_W-2:0]          q_mag;
    logic signed [Q_W-1:0]   sim_val;
    logic                    out_load;

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign similarity     = sim_reg;
    assign zero_magnitude = zflag_reg;

    // 24x24 partial products: cnt[1] picks the half of A, cnt[0] the half of B.
    assign op_a = cnt_reg[1] ? ma_reg[ACC_W-1:HALF_W] : ma_reg[HALF_W-1:0];
    assign op_b = cnt_reg[0] ? mb_reg[ACC_W-1:HALF_W] : mb_reg[HALF_W-1:0];

    always_comb
    begin
        case (pp_sh_reg)
            2'b00:   pp_placed = {{(SQ_W-2*HALF_W){1'b0}}, pp_reg};
            2'b10:   pp_placed = {pp_reg, {(SQ_W-2*HALF_W){1'b0}}};
            default: pp_placed = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
        endcase
    end

    // Square root, one result bit per cycle from the top pair of P.
    assign rem_ext  = {rem_reg, p_reg[SQ_W-1:SQ_W-2]};
    assign trial    = {root_reg, 2'b01};
    assign rem_ge   = (rem_ext >= trial);
    assign rem_diff = rem_ext - trial;
    assign root_next = {root_reg[ACC_W-2:0], rem_ge};

    assign n_ge = (n_reg >= d_reg);

    assign q_mag   = q_reg[Q_W-1] ? SIM_MAX : q_reg[Q_W-2:0];
    assign sim_val = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    cnt_next = '0;
                    if (head.mag_a == '0 || head.mag_b == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd4)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(ACC_W-1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(Q_W-1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ma_reg   <= head.mag_a;
                mb_reg   <= head.mag_b;
                p_reg    <= '0;
                q_reg    <= '0;
                zero_reg <= (head.mag_a == '0 || head.mag_b == '0);
                neg_reg  <= head.dot[ACC_W-1] && head.mag_a != '0 && head.mag_b != '0;
                mag_reg  <= head.dot[ACC_W-1] ? ACC_W'(-head.dot) : ACC_W'(head.dot);
            end
            ST_MUL:
            begin
                pp_reg    <= op_a * op_b;
                pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                if (cnt_reg != '0)
                    p_reg <= p_reg + pp_placed;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                p_reg    <= {p_reg[SQ_W-3:0], 2'b00};
                rem_reg  <= rem_ge ? rem_diff[ACC_W-1:0] : rem_ext[ACC_W-1:0];
                root_reg <= root_next;
                // Dividend mag*2^16 + R, divisor 2R aligned to quotient bit 15.
                n_reg <= {mag_reg, 16'b0} + {16'b0, root_next};
                d_reg <= {root_next, 16'b0};
            end
            ST_DIV:
            begin
                if (n_ge)
                    n_reg <= n_reg - d_reg;
                d_reg <= d_reg >> 1;
                q_reg <= {q_reg[Q_W-2:0], n_ge};
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    sim_reg   <= zero_reg ? '0 : sim_val;
                    zflag_reg <= zero_reg;
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

endmodule

/* hw/rtl/cosine_similarity.sv */
`timescale 1ns / 1ps
// Cosine similarity of two vectors streamed as element pairs.
// Throughput: one element pair per cycle while the queue has room; the back end
// takes each vector pair through pop, 48x48 product, square root, divide and
// load, and on a zero magnitude goes from pop straight to load.
// Reset (rst_n low, asynchronous) clears sums, queue, sequencer and output valid.

module cosine_similarity
    import cossim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic        s_axis_tlast,   // last_elem
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] similarity
    output logic        m_axis_tuser    // [0] zero_magnitude
);

    // Front: registered products and saturating sums, one pair per cycle while the
    // queue has room. A two-entry queue holds finished sums so the front can start
    // the next vector while the back computes root and quotient of the previous one.

    logic                  push, q_full, q_empty, pop;
    acc_rec_t              push_rec, head;
    logic signed [Q_W-1:0] sim;

    cossim_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .elem_a    ($signed(s_axis_tdata[15:0])),
        .elem_b    ($signed(s_axis_tdata[31:16])),
        .last_elem (s_axis_tlast),
        .push      (push),
        .push_rec  (push_rec),
        .q_full    (q_full)
    );

    cossim_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    // Back: product, bit-serial square root, restoring divide, output register.
    cossim_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .similarity     (sim),
        .zero_magnitude (m_axis_tuser)
    );

    assign m_axis_tdata = sim;

endmodule

/* hw/rtl/cossim_checker.sv */
`timescale 1ns / 1ps

module cossim_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Result held until taken.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Zero magnitude forces a zero similarity.
    a_zero_sim: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'h0000)
        else $error("nonzero similarity with zero magnitude");

    // Saturation is symmetric: the most negative code never appears.
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != 16'h8000)
        else $error("similarity outside saturation range");

endmodule

bind cosine_similarity cossim_checker u_cossim_checker (.*);
